@@ hdl/lnr_pkg.sv @@
// Shared constants for the row layer normalization block.
// No dependencies; used by layer_normalization_row.
`timescale 1ns / 1ps

package lnr_pkg;

    localparam int MAX_ROW_DEFAULT     = 128;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // configuration register indexes (byte address bit 2)
    localparam logic REG_ROW_PAIRS = 1'b0;
    localparam logic REG_EPSILON   = 1'b1;

    localparam logic [6:0]  ROW_PAIRS_RESET = 7'd64;
    localparam logic [15:0] EPSILON_RESET   = 16'd168;

    localparam int DIV_W      = 64;  // dividend / quotient width
    localparam int DSR_W      = 25;  // divisor width, holds the root
    localparam int ROOT_STEPS = 25;  // radicand < 2^50, two bits per step
    localparam int FRAC_SHIFT = 20;  // Q4.12 out from root with 8 extra fraction bits

endpackage

@@ hdl/layer_normalization_row.sv @@
// Row layer normalization top level: row buffer, shared divider, square root unit.
// Depends on lnr_pkg.
`timescale 1ns / 1ps

// Requests carry two samples of one row; a row closes on last_of_row or when
// row_pairs pairs (clamped to 1..MAX_ROW/2) have arrived. Loading accepts one
// request per cycle. After the closing request the block stalls its input and
// runs: mean (serial divide), sum of squares (one pair at a time through one
// multiplier and one read port of the row memory), variance divide, root, then
// per pair a memory read and two divides, skipped when the root is zero. The
// last result sits in the output register while the next row loads. The row
// memory needs no clearing pass.
module layer_normalization_row #(
    parameter int MAX_ROW     = lnr_pkg::MAX_ROW_DEFAULT,
    parameter int SAMPLE_BITS = lnr_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_a,
    input  logic signed [SAMPLE_BITS-1:0] sample_b,
    input  logic                          last_of_row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [15:0]            norm_a,
    output logic signed [15:0]            norm_b,
    output logic                          out_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SB     = SAMPLE_BITS;
    localparam int PAIRS  = MAX_ROW / 2;
    localparam int PC_W   = $clog2(PAIRS + 1);
    localparam int AW     = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int SUM_W  = SB + $clog2(MAX_ROW) + 1;
    localparam int MEAN_W = SB + 1;
    localparam int DIFF_W = SB + 2;
    localparam int DW     = lnr_pkg::DIV_W;
    localparam int SW     = lnr_pkg::DSR_W;

    typedef enum logic [15:0] {
        ST_LOAD      = 16'h0001,
        ST_MEAN_DIV  = 16'h0002,
        ST_SQ_RD     = 16'h0004,
        ST_SQ_DIF    = 16'h0008,
        ST_SQ_MULA   = 16'h0010,
        ST_SQ_MULB   = 16'h0020,
        ST_SQ_ACC    = 16'h0040,
        ST_VAR_SETUP = 16'h0080,
        ST_VAR_DIV   = 16'h0100,
        ST_ROOT      = 16'h0200,
        ST_OUT_RD    = 16'h0400,
        ST_OUT_DIF   = 16'h0800,
        ST_OUT_SETA  = 16'h1000,
        ST_A_DIV     = 16'h2000,
        ST_B_DIV     = 16'h4000,
        ST_OUT_EMIT  = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]  row_pairs_reg;
    logic [15:0] epsilon_reg;

    // row memory: one entry per pair, sample_a in the upper half
    logic [2*SB-1:0] row_mem [PAIRS];
    logic [2*SB-1:0] rd_data_reg;
    logic            rd_en;
    logic            wr_en;

    logic [PC_W-1:0]         pair_count_reg, pair_count_next;
    logic [PC_W-1:0]         pairs_reg, pairs_next;
    logic [PC_W-1:0]         idx_reg, idx_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [MEAN_W-1:0] mean_reg, mean_next;
    logic signed [DIFF_W-1:0] diff_a_reg, diff_a_next, diff_b_reg, diff_b_next;
    logic [63:0]             prod_reg, prod_next;
    logic [63:0]             acc_reg, acc_next;
    logic [31:0]             var_reg, var_next;
    logic [SW-1:0]           root_reg, root_next;
    logic [15:0]             ya_reg, ya_next, yb_reg, yb_next;

    // shared serial divider
    logic [DW-1:0] div_dvd_reg, div_dvd_next;
    logic [SW-1:0] div_dsr_reg, div_dsr_next;
    logic [SW-1:0] div_rem_reg, div_rem_next;
    logic          div_neg_reg, div_neg_next;
    logic [5:0]    cnt_reg, cnt_next;

    // square root unit
    logic [49:0] sq_v_reg, sq_v_next;
    logic [25:0] sq_rem_reg, sq_rem_next;
    logic [SW-1:0] sq_root_reg, sq_root_next;

    logic              out_valid_reg, out_valid_next;
    logic [15:0]       norm_a_reg, norm_b_reg;
    logic              out_last_reg;
    logic              out_load;

    function automatic logic [DIFF_W-1:0] mag_of(input logic signed [DIFF_W-1:0] d);
        mag_of = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add64 = s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [DW-1:0] q, input logic neg);
        logic [DW-1:0] nq;
        nq = -q;
        if (!neg)
            sat16 = (q > DW'(32767)) ? 16'h7fff : q[15:0];
        else
            sat16 = (q > DW'(32768)) ? 16'h8000 : nq[15:0];
    endfunction

    // APB
    assign pready = 1'b1;
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            lnr_pkg::REG_ROW_PAIRS: prdata = {25'd0, row_pairs_reg};
            lnr_pkg::REG_EPSILON:   prdata = {16'd0, epsilon_reg};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pairs_reg <= lnr_pkg::ROW_PAIRS_RESET;
            epsilon_reg   <= lnr_pkg::EPSILON_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                lnr_pkg::REG_ROW_PAIRS: row_pairs_reg <= pwdata[6:0];
                lnr_pkg::REG_EPSILON:   epsilon_reg   <= pwdata[15:0];
                default:                row_pairs_reg <= row_pairs_reg;
            endcase
        end
    end

    // effective row limit
    logic [7:0]      limit;
    logic [PC_W-1:0] cnt_inc;
    logic            in_acc;
    logic            row_close;
    logic [SUM_W-1:0] sum_mag;

    always_comb
    begin
        if (row_pairs_reg == 7'd0)
            limit = 8'd1;
        else if ({1'b0, row_pairs_reg} > 8'(PAIRS))
            limit = 8'(PAIRS);
        else
            limit = {1'b0, row_pairs_reg};
    end

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign cnt_inc   = pair_count_reg + PC_W'(1);
    assign row_close = last_of_row || (8'(cnt_inc) >= limit);
    assign sum_mag   = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
    assign wr_en     = in_acc;
    assign rd_en     = (state_reg == ST_SQ_RD) || (state_reg == ST_OUT_RD);
    assign out_load  = (state_reg == ST_OUT_EMIT) && (!out_valid_reg || !out_stall);

    // datapath helpers
    logic [SW:0]     rem_sh;
    logic [SW:0]     rem_sub;
    logic            div_ge;
    logic [DW-1:0]   div_q;
    logic [27:0]     rt_sh;
    logic [27:0]     rt_trial;
    logic            rt_ge;
    logic [63:0]     mul_in;
    logic [63:0]     square;
    logic [DIFF_W-1:0] mag_a, mag_b;
    logic [32:0]     rad;
    logic            last_pair;

    assign rem_sh  = {div_rem_reg, div_dvd_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, div_dsr_reg};
    assign div_ge  = rem_sh >= {1'b0, div_dsr_reg};
    assign div_q   = {div_dvd_reg[DW-2:0], div_ge};

    assign rt_sh    = {sq_rem_reg, sq_v_reg[49:48]};
    assign rt_trial = {1'b0, sq_root_reg, 2'b01};
    assign rt_ge    = rt_sh >= rt_trial;

    assign mag_a  = mag_of(diff_a_reg);
    assign mag_b  = mag_of(diff_b_reg);
    assign mul_in = (state_reg == ST_SQ_MULA) ? 64'(mag_a) : 64'(mag_b);
    assign square = (|mul_in[63:32]) ? '1 : mul_in[31:0] * mul_in[31:0];
    assign rad    = 33'(var_reg) + 33'(epsilon_reg);
    assign last_pair = (idx_reg + PC_W'(1)) == pairs_reg;

    always_comb
    begin
        state_next      = state_reg;
        pair_count_next = pair_count_reg;
        pairs_next      = pairs_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        mean_next       = mean_reg;
        diff_a_next     = diff_a_reg;
        diff_b_next     = diff_b_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        var_next        = var_reg;
        root_next       = root_reg;
        ya_next         = ya_reg;
        yb_next         = yb_reg;
        div_dvd_next    = div_dvd_reg;
        div_dsr_next    = div_dsr_reg;
        div_rem_next    = div_rem_reg;
        div_neg_next    = div_neg_reg;
        cnt_next        = cnt_reg;
        sq_v_next       = sq_v_reg;
        sq_rem_next     = sq_rem_reg;
        sq_root_next    = sq_root_reg;

        if (in_acc)
            sum_next = sum_reg + SUM_W'(sample_a) + SUM_W'(sample_b);

        // divider steps in every divide state
        if ((state_reg == ST_MEAN_DIV) || (state_reg == ST_VAR_DIV) ||
            (state_reg == ST_A_DIV) || (state_reg == ST_B_DIV))
        begin
            div_dvd_next = div_q;
            div_rem_next = div_ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
            cnt_next     = cnt_reg + 6'd1;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (row_close)
                    begin
                        pairs_next      = cnt_inc;
                        pair_count_next = '0;
                        div_dvd_next    = DW'(sum_mag) + DW'(cnt_inc);
                        div_dsr_next    = SW'({cnt_inc, 1'b0});
                        div_rem_next    = '0;
                        div_neg_next    = sum_next[SUM_W-1];
                        cnt_next        = '0;
                        state_next      = ST_MEAN_DIV;
                    end
                    else
                    begin
                        pair_count_next = cnt_inc;
                    end
                end
            end
            ST_MEAN_DIV:
            begin
                if (cnt_reg == 6'(DW - 1))
                begin
                    mean_next  = div_neg_reg ? MEAN_W'(-div_q) : MEAN_W'(div_q);
                    sum_next   = '0;
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = ST_SQ_RD;
                end
            end
            ST_SQ_RD:
            begin
                state_next = ST_SQ_DIF;
            end
            ST_SQ_DIF, ST_OUT_DIF:
            begin
                diff_a_next = DIFF_W'($signed(rd_data_reg[2*SB-1:SB])) - DIFF_W'(mean_reg);
                diff_b_next = DIFF_W'($signed(rd_data_reg[SB-1:0])) - DIFF_W'(mean_reg);
                state_next  = (state_reg == ST_SQ_DIF) ? ST_SQ_MULA : ST_OUT_SETA;
            end
            ST_SQ_MULA:
            begin
                prod_next  = square;
                state_next = ST_SQ_MULB;
            end
            ST_SQ_MULB:
            begin
                acc_next   = sat_add64(acc_reg, prod_reg);
                prod_next  = square;
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                acc_next = sat_add64(acc_reg, prod_reg);
                if (last_pair)
                    state_next = ST_VAR_SETUP;
                else
                begin
                    idx_next   = idx_reg + PC_W'(1);
                    state_next = ST_SQ_RD;
                end
            end
            ST_VAR_SETUP:
            begin
                div_dvd_next = sat_add64(acc_reg, 64'(pairs_reg));
                div_dsr_next = SW'({pairs_reg, 1'b0});
                div_rem_next = '0;
                cnt_next     = '0;
                state_next   = ST_VAR_DIV;
            end
            ST_VAR_DIV:
            begin
                if (cnt_reg == 6'(DW - 1))
                begin
                    var_next     = (|div_q[63:32]) ? 32'hffff_ffff : div_q[31:0];
                    cnt_next     = '0;
                    state_next   = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                // var_reg is settled here; radicand loads on the first step
                if (cnt_reg == 6'd0)
                begin
                    sq_v_next    = {1'b0, rad, 16'd0};
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    cnt_next     = 6'd1;
                end
                else
                begin
                    sq_v_next    = {sq_v_reg[47:0], 2'b00};
                    sq_rem_next  = rt_ge ? 26'(rt_sh - rt_trial) : 26'(rt_sh);
                    sq_root_next = {sq_root_reg[SW-2:0], rt_ge};
                    cnt_next     = cnt_reg + 6'd1;
                    if (cnt_reg == 6'(lnr_pkg::ROOT_STEPS))
                    begin
                        root_next  = {sq_root_reg[SW-2:0], rt_ge};
                        idx_next   = '0;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_DIF;
            end
            ST_OUT_SETA:
            begin
                if (root_reg == '0)
                begin
                    ya_next    = '0;
                    yb_next    = '0;
                    state_next = ST_OUT_EMIT;
                end
                else
                begin
                    div_dvd_next = (DW'(mag_a) << lnr_pkg::FRAC_SHIFT) + DW'(root_reg >> 1);
                    div_dsr_next = root_reg;
                    div_rem_next = '0;
                    div_neg_next = diff_a_reg[DIFF_W-1];
                    cnt_next     = '0;
                    state_next   = ST_A_DIV;
                end
            end
            ST_A_DIV:
            begin
                if (cnt_reg == 6'(DW - 1))
                begin
                    ya_next      = sat16(div_q, div_neg_reg);
                    div_dvd_next = (DW'(mag_b) << lnr_pkg::FRAC_SHIFT) + DW'(root_reg >> 1);
                    div_rem_next = '0;
                    div_neg_next = diff_b_reg[DIFF_W-1];
                    cnt_next     = '0;
                    state_next   = ST_B_DIV;
                end
            end
            ST_B_DIV:
            begin
                if (cnt_reg == 6'(DW - 1))
                begin
                    yb_next    = sat16(div_q, div_neg_reg);
                    state_next = ST_OUT_EMIT;
                end
            end
            ST_OUT_EMIT:
            begin
                if (out_load)
                begin
                    if (last_pair)
                        state_next = ST_LOAD;
                    else
                    begin
                        idx_next   = idx_reg + PC_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            pair_count_reg <= '0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pair_count_reg <= pair_count_next;
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pairs_reg   <= pairs_next;
        idx_reg     <= idx_next;
        mean_reg    <= mean_next;
        diff_a_reg  <= diff_a_next;
        diff_b_reg  <= diff_b_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        var_reg     <= var_next;
        root_reg    <= root_next;
        ya_reg      <= ya_next;
        yb_reg      <= yb_next;
        div_dvd_reg <= div_dvd_next;
        div_dsr_reg <= div_dsr_next;
        div_rem_reg <= div_rem_next;
        div_neg_reg <= div_neg_next;
        sq_v_reg    <= sq_v_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        if (out_load)
        begin
            norm_a_reg   <= ya_reg;
            norm_b_reg   <= yb_reg;
            out_last_reg <= last_pair;
        end
    end

    // row memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            row_mem[pair_count_reg[AW-1:0]] <= {sample_a, sample_b};
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= row_mem[idx_reg[AW-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign norm_a    = norm_a_reg;
    assign norm_b    = norm_b_reg;
    assign out_last  = out_last_reg;

endmodule

@@ hdl/lnr_checker.sv @@
// Port-level checks for layer_normalization_row, bound to the top level.
// No package dependencies.
`timescale 1ns / 1ps

module lnr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last_of_row,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] norm_a,
    input logic [15:0] norm_b,
    input logic        out_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(norm_a) && $stable(norm_b)
            && $stable(out_last))
        else $error("stalled result changed");

    // closing request starts row processing
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_of_row |=> in_stall)
        else $error("input not stalled after row close");

    // results appear only out of row processing
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without row processing");

    // nothing follows the last pair right away
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last && !out_stall |=> !out_valid)
        else $error("result right after last pair");

endmodule

bind layer_normalization_row lnr_checker u_lnr_checker (.*);

@@ dv/tb.sv @@
// Testbench for layer_normalization_row: drives rows of sample pairs, checks the
// normalized pairs against a fixed-point row normalizer kept in this file.
// Depends on lnr_pkg and the layer_normalization_row RTL.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               last;
    } pair_t;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               last;
        logic               known;   // result typed in by hand
        logic signed [15:0] exp_a;
        logic signed [15:0] exp_b;
    } row_req_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic last_of_row;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] norm_a;
    logic signed [15:0] norm_b;
    logic out_last;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    // predictor state
    logic [6:0]  cfg_row_pairs;
    logic [15:0] cfg_epsilon;
    logic signed [15:0] row_buf [0:127];
    int unsigned row_fill;
    longint     row_sum;

    pair_t norm_q[$];
    int    fail_count;
    bit    quiet;      // no idling near the end
    bit    known_pending;
    logic signed [15:0] known_a;
    logic signed [15:0] known_b;

    layer_normalization_row u_dut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #400ms;
        $display("Verification failed");
        $finish;
    end

    task automatic report(input string what, input logic signed [31:0] got,
                          input logic signed [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic longint div_near(longint num, longint unsigned d);
        longint unsigned m;
        longint unsigned q;
        m = (num < 0) ? longint'(-num) : num;
        q = (m + d / 2) / d;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    // load one pair; on row close, push the normalized row
    task automatic normalize_pair(input pair_t p);
        int unsigned lim;
        int unsigned n;
        longint mean;
        longint unsigned sq;
        longint unsigned mag;
        longint unsigned var_q;
        longint unsigned root;
        pair_t r;
        lim = cfg_row_pairs;
        if (lim < 1)
            lim = 1;
        if (lim > 64)
            lim = 64;
        if (row_fill >= 64)
            row_fill = 0;
        row_buf[2*row_fill] = p.a;
        row_buf[2*row_fill+1] = p.b;
        row_sum += longint'(p.a) + longint'(p.b);
        row_fill++;
        if (!p.last && row_fill < lim)
            return;
        n = 2 * row_fill;
        mean = div_near(row_sum, n);
        sq = 0;
        for (int i = 0; i < n; i++)
        begin
            mag = (row_buf[i] - mean < 0) ? -(row_buf[i] - mean) : row_buf[i] - mean;
            sq += mag * mag;   // bounded by 128 * 2^32, no overflow
        end
        var_q = (sq + n / 2) / n;
        if (var_q > 64'hFFFF_FFFF)
            var_q = 64'hFFFF_FFFF;
        root = root_floor((var_q + cfg_epsilon) << 16);
        for (int i = 0; i < row_fill; i++)
        begin
            r.a = '0;
            r.b = '0;
            if (root != 0)
            begin
                r.a = clamp16(div_near((row_buf[2*i] - mean) * 1048576, root));
                r.b = clamp16(div_near((row_buf[2*i+1] - mean) * 1048576, root));
            end
            r.last = (i + 1 == row_fill);
            norm_q.push_back(r);
        end
        row_sum = 0;
        row_fill = 0;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == lnr_pkg::REG_ROW_PAIRS)
            cfg_row_pairs = value[6:0];
        else
            cfg_epsilon = value[15:0];
    endtask

    task automatic send_pair(input pair_t p);
        if (!quiet && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 14)) @(negedge clk);
        in_valid = 1'b1;
        sample_a = p.a;
        sample_b = p.b;
        last_of_row = p.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        normalize_pair(p);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // wait until the block is idle again
    task automatic drain();
        int guard;
        guard = 0;
        while (norm_q.size() != 0 && guard < 2000000)
        begin
            @(posedge clk);
            guard++;
        end
        if (guard >= 2000000)
        begin
            $display("Verification failed");
            $finish;
        end
        repeat (300) @(negedge clk);
    endtask

    // receive side: random stall bursts, compare each result
    always @(negedge clk)
    begin
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        pair_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (norm_q.size() == 0)
                report("unexpected result", norm_a, 0);
            else
            begin
                e = norm_q.pop_front();
                if (known_pending)
                begin
                    if (norm_a !== known_a)
                        report("norm_a table", norm_a, known_a);
                    if (norm_b !== known_b)
                        report("norm_b table", norm_b, known_b);
                    known_pending = 1'b0;
                end
                if (norm_a !== e.a)
                    report("norm_a", norm_a, e.a);
                if (norm_b !== e.b)
                    report("norm_b", norm_b, e.b);
                if (out_last !== e.last)
                    report("out_last", out_last, e.last);
            end
        end
    end

    row_req_t table_rows[] = '{
        // single pair, extremes: mean -0.5 lsb rounds away, deviation near one sigma
        '{16'sh7FFF, -16'sh8000, 1'b1, 1'b1, 16'sd4096, -16'sd4096},
        '{16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd0, 16'sd0},
        '{16'sd4096, -16'sd4096, 1'b1, 1'b1, 16'sd4096, -16'sd4096},
        '{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 16'sd0, 16'sd0},
        '{-16'sh8000, -16'sh8000, 1'b1, 1'b1, 16'sd0, 16'sd0},
        '{16'sd1, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{16'sh5555, -16'sh2AAB, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{16'sh7FFF, -16'sh8000, 1'b1, 1'b0, 16'sd0, 16'sd0},
        '{16'sd7, 16'sd7, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{16'sd7, 16'sd9, 1'b1, 1'b0, 16'sd0, 16'sd0}
    };

    task automatic random_rows(input int reqs);
        pair_t p;
        int mode;
        for (int k = 0; k < reqs; k++)
        begin
            mode = $urandom_range(0, 3);
            p.a = 16'($urandom);
            p.b = 16'($urandom);
            if (mode == 0)
            begin
                p.a = $signed(p.a) >>> 10;  // small spread, near zero variance
                p.b = p.a + $signed(p.b[2:0]);
            end
            p.last = ($urandom_range(0, 9) == 0);
            send_pair(p);
        end
    endtask

    initial
    begin
        pair_t p;
        logic [31:0] regs_pairs[];
        logic [31:0] regs_eps[];
        regs_pairs = '{32'd1, 32'd3, 32'd0, 32'd127, 32'd5};
        regs_eps = '{32'd0, 32'd65535, 32'd168, 32'd1, 32'd40000};
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_a = '0;
        sample_b = '0;
        last_of_row = 1'b0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        quiet = 1'b0;
        known_pending = 1'b0;
        cfg_row_pairs = lnr_pkg::ROW_PAIRS_RESET;
        cfg_epsilon = lnr_pkg::EPSILON_RESET;
        row_fill = 0;
        row_sum = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows at reset settings; single-pair rows have a known answer
        foreach (table_rows[i])
        begin
            p.a = table_rows[i].a;
            p.b = table_rows[i].b;
            p.last = table_rows[i].last;
            if (table_rows[i].known)
            begin
                drain();
                known_a = table_rows[i].exp_a;
                known_b = table_rows[i].exp_b;
                known_pending = 1'b1;
            end
            send_pair(p);
        end
        // zero root: equal samples with zero epsilon
        drain();
        write_reg(lnr_pkg::REG_EPSILON, 32'd0);
        p.a = 16'sd300;
        p.b = 16'sd300;
        p.last = 1'b1;
        send_pair(p);
        // full 64-pair row closing on count, no last flag
        drain();
        write_reg(lnr_pkg::REG_ROW_PAIRS, 32'd64);
        write_reg(lnr_pkg::REG_EPSILON, 32'd65535);
        for (int k = 0; k < 64; k++)
        begin
            p.a = 16'($urandom);
            p.b = 16'($urandom);
            p.last = 1'b0;
            send_pair(p);
        end

        foreach (regs_pairs[i])
        begin
            drain();
            write_reg(lnr_pkg::REG_ROW_PAIRS, regs_pairs[i]);
            write_reg(lnr_pkg::REG_EPSILON, regs_eps[i]);
            if (i == 4)
                quiet = 1'b1;
            random_rows(i == 3 ? 20 : 40);
        end
        // close any open row
        p.a = 16'sd1;
        p.b = -16'sd1;
        p.last = 1'b1;
        send_pair(p);
        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
